// File: rtl/stereo_block_rms_meter_core_macros.svh
// assertion macros for the stereo block rms meter
// used by stereo_block_rms_meter_core, no other dependencies
`ifndef STEREO_BLOCK_RMS_METER_CORE_MACROS_SVH
`define STEREO_BLOCK_RMS_METER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SRMS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("srms assertion failed");
`define SRMS_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("srms assertion failed");
`else
`define SRMS_ASSERT(lbl, clk, rstn, prop)
`define SRMS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/srms_pkg.sv
// shared constants, types and sample normalization for the block rms meter
// no dependencies
package srms_pkg;

	localparam int CFG_W          = 14;
	localparam int REG_IDX_W      = 2;
	localparam int SAMPLE_W       = 16;
	localparam int RAW_W          = 32;
	localparam int SQ_W           = 30;
	localparam int RAD_W          = 32;
	localparam int ROOT_W         = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int COUNT_BITS_DEF = 14;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_FRAMES  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE   = 2'd2;

	localparam logic [1:0] FMT_S16 = 2'd0;
	localparam logic [1:0] FMT_S32 = 2'd1;
	localparam logic [1:0] FMT_U8  = 2'd2;

	localparam logic [CFG_W-1:0] BLOCK_FRAMES_RST = 14'd2400;
	localparam logic [1:0]       FORMAT_RST       = FMT_S16;
	localparam logic             STEREO_RST       = 1'b1;

	typedef struct packed {
		logic start;
		logic ack;
	} ds_ctrl_t;

	function automatic logic signed [SAMPLE_W-1:0] normalize(
		input logic [RAW_W-1:0] raw,
		input logic [1:0]       fmt
	);
		logic signed [SAMPLE_W-1:0] v;
		case (fmt)
			FMT_S16: v = raw[15:0];
			FMT_S32: v = raw[31:16];
			default: v = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
		endcase
		return v;
	endfunction

endpackage

// File: rtl/srms_queue.sv
// small fifo of finished block sums between the accumulator and the root unit
// uses srms_pkg for the default depth
module srms_queue #(
	parameter int W     = 89,
	parameter int DEPTH = srms_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [W-1:0]               wdata,
	input  logic                       rd,
	output logic [W-1:0]               rdata,
	output logic [$clog2(DEPTH+1)-1:0] level,
	output logic                       full,
	output logic                       empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [LW-1:0] level_q;

	assign rdata = mem_q[rptr_q];
	assign level = level_q;
	assign full  = level_q == LW'(DEPTH);
	assign empty = level_q == '0;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				level_q <= level_q + 1'b1;
			end else if (rd && !wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end
endmodule

// File: rtl/srms_front.sv
// front end: accepts frames, normalizes, squares and accumulates per channel
// uses srms_pkg; pushes finished block sums into srms_queue
module srms_front #(
	parameter int COUNT_BITS = srms_pkg::COUNT_BITS_DEF,
	parameter int SUM_W      = srms_pkg::SQ_W + COUNT_BITS,
	parameter int LVL_W      = $clog2(srms_pkg::QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [srms_pkg::RAW_W-1:0]    left_sample,
	input  logic [srms_pkg::RAW_W-1:0]    right_sample,
	input  logic [srms_pkg::CFG_W-1:0]    block_frames,
	input  logic [1:0]                    sample_format,
	input  logic                          stereo_mode,
	input  logic [LVL_W-1:0]              q_level,
	output logic                          push,
	output logic [SUM_W-1:0]              push_sum_l,
	output logic [SUM_W-1:0]              push_sum_r,
	output logic [COUNT_BITS-1:0]         push_count,
	output logic                          push_partial
);
	localparam int CMP_W = (COUNT_BITS > srms_pkg::CFG_W) ? COUNT_BITS : srms_pkg::CFG_W;
	localparam int SW    = srms_pkg::SAMPLE_W;

	logic                        accept;
	logic [LVL_W:0]              occ;
	logic                        valid_s1, kind_s1;
	logic signed [SW-1:0]        sl_s1, sr_s1;
	logic                        valid_s2, kind_s2;
	logic [srms_pkg::SQ_W:0]     sq_l_s2, sq_r_s2;
	logic signed [2*SW-1:0]      prod_l, prod_r;
	logic [SUM_W-1:0]            sum_l_q, sum_r_q, sum_l_nx, sum_r_nx;
	logic [COUNT_BITS-1:0]       count_q, cnt_nx;
	logic [srms_pkg::CFG_W-1:0]  limit;
	logic                        full_end;
	logic                        fmt_ok;
	logic signed [SW-1:0]        norm_l;

	assign occ      = {1'b0, q_level} + (LVL_W+1)'(valid_s1) + (LVL_W+1)'(valid_s2);
	assign in_ready = occ < (LVL_W+1)'(srms_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign fmt_ok   = sample_format inside {srms_pkg::FMT_S16, srms_pkg::FMT_S32,
		srms_pkg::FMT_U8};
	assign norm_l   = srms_pkg::normalize(left_sample, sample_format);

	assign prod_l = sl_s1 * sl_s1;
	assign prod_r = sr_s1 * sr_s1;

	assign sum_l_nx = sum_l_q + SUM_W'(sq_l_s2);
	assign sum_r_nx = sum_r_q + SUM_W'(sq_r_s2);
	assign cnt_nx   = count_q + 1'b1;
	assign limit    = (block_frames == '0) ? srms_pkg::CFG_W'(1) : block_frames;
	assign full_end = (CMP_W'(cnt_nx) >= CMP_W'(limit)) || (cnt_nx == '1);

	assign push         = valid_s2 && (kind_s2 ? (count_q != '0) : full_end);
	assign push_sum_l   = kind_s2 ? sum_l_q : sum_l_nx;
	assign push_sum_r   = kind_s2 ? sum_r_q : sum_r_nx;
	assign push_count   = kind_s2 ? count_q : cnt_nx;
	assign push_partial = kind_s2;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			sl_s1   <= norm_l;
			sr_s1   <= stereo_mode ? srms_pkg::normalize(right_sample, sample_format) : norm_l;
		end
		if (valid_s1) begin
			kind_s2 <= kind_s1;
			sq_l_s2 <= prod_l[srms_pkg::SQ_W:0];
			sq_r_s2 <= prod_r[srms_pkg::SQ_W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_l_q  <= '0;
			sum_r_q  <= '0;
			count_q  <= '0;
		end else begin
			// frames in an unknown format are dropped here
			valid_s1 <= accept && (kind || fmt_ok);
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (kind_s2 || full_end) begin
					sum_l_q <= '0;
					sum_r_q <= '0;
					count_q <= '0;
				end else begin
					sum_l_q <= sum_l_nx;
					sum_r_q <= sum_r_nx;
					count_q <= cnt_nx;
				end
			end
		end
	end
endmodule

// File: rtl/srms_divsqrt.sv
// one channel: shift-subtract divide of the square sum by the count,
// then digit-by-digit integer square root; uses srms_pkg
module srms_divsqrt #(
	parameter int COUNT_BITS = srms_pkg::COUNT_BITS_DEF,
	parameter int SUM_W      = srms_pkg::SQ_W + COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srms_pkg::ds_ctrl_t          ctrl,
	input  logic [SUM_W-1:0]            dividend,
	input  logic [COUNT_BITS-1:0]       divisor,
	output logic                        done,
	output logic [srms_pkg::ROOT_W-1:0] root
);
	localparam int STEP_W = $clog2(SUM_W);
	localparam int RW     = srms_pkg::ROOT_W;
	localparam int RADW   = srms_pkg::RAD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [STEP_W-1:0]     step_q;
	logic [SUM_W-1:0]      acc_q, acc_nx;
	logic [COUNT_BITS-1:0] div_q, rem_q, rem_nx;
	logic [COUNT_BITS:0]   rs, rs_diff;
	logic                  qbit;
	logic [RADW-1:0]       rad_q;
	logic [RW+1:0]         srem_q;
	logic [RW-1:0]         root_q;
	logic [RW+3:0]         sr, trial, sr_diff;
	logic                  rbit;

	assign rs      = {rem_q, acc_q[SUM_W-1]};
	assign rs_diff = rs - {1'b0, div_q};
	assign qbit    = rs >= {1'b0, div_q};
	assign rem_nx  = qbit ? rs_diff[COUNT_BITS-1:0] : rs[COUNT_BITS-1:0];
	assign acc_nx  = {acc_q[SUM_W-2:0], qbit};

	assign sr      = {srem_q, rad_q[RADW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sr_diff = sr - trial;
	assign rbit    = sr >= trial;

	assign done = state_q == ST_DONE;
	assign root = root_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q <= dividend;
				div_q <= divisor;
				rem_q <= '0;
			end
			ST_DIV: begin
				acc_q <= acc_nx;
				rem_q <= rem_nx;
				// the mean of squares never exceeds 2^30, so the low bits hold it
				rad_q  <= acc_nx[RADW-1:0];
				srem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[RADW-3:0], 2'b00};
				srem_q <= rbit ? sr_diff[RW+1:0] : sr[RW+1:0];
				root_q <= {root_q[RW-2:0], rbit};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(SUM_W - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SQRT;
						step_q  <= STEP_W'(RW - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (ctrl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/srms_back.sv
// back end: takes block sums from the queue, runs both channels through
// srms_divsqrt and holds the result in the output register; uses srms_pkg
module srms_back #(
	parameter int COUNT_BITS = srms_pkg::COUNT_BITS_DEF,
	parameter int SUM_W      = srms_pkg::SQ_W + COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [SUM_W-1:0]            q_sum_l,
	input  logic [SUM_W-1:0]            q_sum_r,
	input  logic [COUNT_BITS-1:0]       q_count,
	input  logic                        q_partial,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srms_pkg::ROOT_W-1:0] rms_left,
	output logic [srms_pkg::ROOT_W-1:0] rms_right,
	output logic                        partial_block
);
	logic                        busy_q, partial_q, out_valid_q;
	logic                        done_l, done_r, load;
	logic [srms_pkg::ROOT_W-1:0] root_l, root_r;
	srms_pkg::ds_ctrl_t          ctrl;

	assign q_pop     = !busy_q && !q_empty;
	assign load      = busy_q && done_l && done_r && (!out_valid_q || out_ready);
	assign ctrl      = '{start: q_pop, ack: load};
	assign out_valid = out_valid_q;

	srms_divsqrt #(.COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_ds_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.dividend (q_sum_l),
		.divisor  (q_count),
		.done     (done_l),
		.root     (root_l)
	);

	srms_divsqrt #(.COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_ds_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.dividend (q_sum_r),
		.divisor  (q_count),
		.done     (done_r),
		.root     (root_r)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			partial_q <= q_partial;
		end
		if (load) begin
			rms_left      <= root_l;
			rms_right     <= root_r;
			partial_block <= partial_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/stereo_block_rms_meter_core.sv
// channel  | dir | payload
// s_*      | in  | tdata: left_sample[31:0], right_sample[63:32]; tuser: kind
// m_*      | out | tdata: rms_left[15:0], rms_right[31:16]; tuser: partial_block
// cfg_*    | in  | write of block_frames, sample_format, stereo_mode by index
// frames are taken one per cycle while the queue of finished blocks has room;
// each block result is formed by the per-channel shift-subtract divide and the
// 16-step root
// the queue holds four finished blocks; input stalls once queue plus pipeline fill it
// reset restores register defaults and clears sums, count, queue and output
// top level: configuration registers, front, queue and back; uses srms_pkg
// and stereo_block_rms_meter_core_macros.svh
`include "stereo_block_rms_meter_core_macros.svh"

module stereo_block_rms_meter_core #(
	parameter int COUNT_BITS = srms_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [63:0]                      s_tdata,  // left_sample, right_sample
	input  logic                             s_tuser,  // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,  // rms_left, rms_right
	output logic                             m_tuser,  // partial_block
	input  logic                             cfg_we,
	input  logic [srms_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [srms_pkg::CFG_W-1:0]       cfg_data
);
	localparam int SUM_W = srms_pkg::SQ_W + COUNT_BITS;
	localparam int QW    = 2 * SUM_W + COUNT_BITS + 1;
	localparam int LVL_W = $clog2(srms_pkg::QUEUE_DEPTH + 1);

	logic [srms_pkg::CFG_W-1:0] block_frames_q;
	logic [1:0]                 sample_format_q;
	logic                       stereo_mode_q;

	logic                  q_push, q_pop, q_full, q_empty;
	logic [LVL_W-1:0]      q_level;
	logic [SUM_W-1:0]      push_sum_l, push_sum_r;
	logic [COUNT_BITS-1:0] push_count;
	logic                  push_partial;
	logic [QW-1:0]         q_wdata, q_rdata;
	logic [srms_pkg::ROOT_W-1:0] rms_left, rms_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames_q  <= srms_pkg::BLOCK_FRAMES_RST;
			sample_format_q <= srms_pkg::FORMAT_RST;
			stereo_mode_q   <= srms_pkg::STEREO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				srms_pkg::REG_BLOCK_FRAMES:  block_frames_q  <= cfg_data;
				srms_pkg::REG_SAMPLE_FORMAT: sample_format_q <= cfg_data[1:0];
				srms_pkg::REG_STEREO_MODE:   stereo_mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	srms_front #(.COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W), .LVL_W(LVL_W)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.kind          (s_tuser),
		.left_sample   (s_tdata[31:0]),
		.right_sample  (s_tdata[63:32]),
		.block_frames  (block_frames_q),
		.sample_format (sample_format_q),
		.stereo_mode   (stereo_mode_q),
		.q_level       (q_level),
		.push          (q_push),
		.push_sum_l    (push_sum_l),
		.push_sum_r    (push_sum_r),
		.push_count    (push_count),
		.push_partial  (push_partial)
	);

	assign q_wdata = {push_partial, push_count, push_sum_r, push_sum_l};

	srms_queue #(.W(QW), .DEPTH(srms_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.level  (q_level),
		.full   (q_full),
		.empty  (q_empty)
	);

	srms_back #(.COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_sum_l       (q_rdata[SUM_W-1:0]),
		.q_sum_r       (q_rdata[2*SUM_W-1:SUM_W]),
		.q_count       (q_rdata[2*SUM_W+COUNT_BITS-1:2*SUM_W]),
		.q_partial     (q_rdata[QW-1]),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.rms_left      (rms_left),
		.rms_right     (rms_right),
		.partial_block (m_tuser)
	);

	assign m_tdata = {rms_right, rms_left};

	`SRMS_ASSERT(a_no_overflow, clk, arst_n, q_push |-> !q_full)
	`SRMS_ASSERT(a_no_underflow, clk, arst_n, q_pop |-> !q_empty)
	`SRMS_ASSERT(a_full_stalls, clk, arst_n, q_full |-> !s_tready)
endmodule

// File: tb/sv/tb_stereo_block_rms_meter_core.sv
// self-checking bench for stereo_block_rms_meter_core: a directed table, then random
// phases; block results are predicted in-bench and checked in order
// depends on srms_pkg and the rtl top level
module tb_stereo_block_rms_meter_core;

	localparam int         CLK_HALF   = 5;
	localparam int         SETTLE     = 100;
	localparam int         WD_LIMIT   = 2000;
	localparam int         RAND_ITEMS = 1750;
	localparam int         CNT_MAX    = (1 << srms_pkg::COUNT_BITS_DEF) - 1;
	localparam int         N_STEPS    = 30;
	localparam logic       KIND_AUDIO = 1'b0;
	localparam logic       KIND_FLUSH = 1'b1;
	localparam logic [1:0] FMT_BAD    = 2'd3;

	localparam int REG_IDX_W = srms_pkg::REG_IDX_W;
	localparam int CFG_W     = srms_pkg::CFG_W;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_FRAMES  = srms_pkg::REG_BLOCK_FRAMES;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = srms_pkg::REG_SAMPLE_FORMAT;
	localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE   = srms_pkg::REG_STEREO_MODE;

	localparam logic [1:0] FMT_S16 = srms_pkg::FMT_S16;
	localparam logic [1:0] FMT_S32 = srms_pkg::FMT_S32;
	localparam logic [1:0] FMT_U8  = srms_pkg::FMT_U8;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG} op_t;
	typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_RES} chk_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        partial;
	} rms_t;

	typedef struct packed {
		op_t                  op;
		logic [REG_IDX_W-1:0] idx;
		logic                 kind;
		logic [31:0]          left;
		logic [31:0]          right;
		chk_t                 chk;
		rms_t                 res;
	} step_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// in-bench copy of the meter registers and block state
	logic [CFG_W-1:0] want_frames;
	logic [1:0]       want_fmt;
	logic             want_stereo;
	logic [63:0]      sumsq_l;
	logic [63:0]      sumsq_r;
	int               blk_count;

	rms_t  rms_due [$];
	step_t dir_steps [N_STEPS];
	logic  quiet;
	int    errors;
	int    n_frames;
	int    n_flushes;
	int    n_ignored;
	int    n_results;
	int    n_phases;
	int    idle_cycles;

	stereo_block_rms_meter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int to_q15(logic [31:0] raw, logic [1:0] fmt);
		int v;
		case (fmt)
			FMT_S16: v = int'($signed(raw[15:0]));
			FMT_S32: v = int'($signed(raw[31:16]));
			default: v = (int'(raw[7:0]) - 128) * 256;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] root_floor(logic [63:0] x);
		logic [16:0] r;
		logic [16:0] t;
		r = '0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (17'd1 << b);
			if (64'(t) * 64'(t) <= x)
				r = t;
		end
		return r[15:0];
	endfunction

	function automatic rms_t block_rms(logic partial);
		rms_t res;
		res.left    = root_floor(sumsq_l / 64'(blk_count));
		res.right   = root_floor(sumsq_r / 64'(blk_count));
		res.partial = partial;
		return res;
	endfunction

	function automatic logic [31:0] pick_sample();
		logic [31:0] corners [8];
		corners = '{32'h0000_7FFF, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_0080};
		if ($urandom_range(0, 7) == 0)
			return corners[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic meter_step(input logic kind, input logic [31:0] l, input logic [31:0] r,
			output logic got, output rms_t res);
		int sl;
		int sr;
		int lim;
		got = 1'b0;
		res = '0;
		if (kind == KIND_FLUSH) begin
			if (blk_count != 0) begin
				got = 1'b1;
				res = block_rms(1'b1);
			end
			sumsq_l = '0;
			sumsq_r = '0;
			blk_count = 0;
		end else if (want_fmt != FMT_BAD) begin
			sl = to_q15(l, want_fmt);
			sr = want_stereo ? to_q15(r, want_fmt) : sl;
			sumsq_l += 64'(longint'(sl) * longint'(sl));
			sumsq_r += 64'(longint'(sr) * longint'(sr));
			blk_count = (blk_count + 1) & CNT_MAX;
			lim = (want_frames == 0) ? 1 : int'(want_frames);
			if (blk_count >= lim || blk_count == CNT_MAX) begin
				got = 1'b1;
				res = block_rms(1'b0);
				sumsq_l = '0;
				sumsq_r = '0;
				blk_count = 0;
			end
		end
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BLOCK_FRAMES: want_frames = val[CFG_W-1:0];
			REG_SAMPLE_FORMAT: want_fmt = val[1:0];
			REG_STEREO_MODE: want_stereo = val[0];
			default: ;
		endcase
	endtask

	// hold the sender until every predicted block has come out, then let the pipe settle
	task automatic drain(input int settle);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (rms_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic send(input logic kind, input logic [31:0] l, input logic [31:0] r,
			output logic got, output rms_t res);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {r, l};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_FLUSH)
			n_flushes++;
		else if (want_fmt == FMT_BAD)
			n_ignored++;
		else
			n_frames++;
		meter_step(kind, l, r, got, res);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		rms_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rms_due.size() == 0) begin
				$error("unexpected result rms_left=%0d rms_right=%0d partial_block=%0d",
					m_tdata[15:0], m_tdata[31:16], m_tuser);
				errors++;
			end else begin
				want = rms_due.pop_front();
				n_results++;
				if (m_tdata[15:0] !== want.left) begin
					$error("rms_left expected %0d actual %0d", want.left, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== want.right) begin
					$error("rms_right expected %0d actual %0d", want.right, m_tdata[31:16]);
					errors++;
				end
				if (m_tuser !== want.partial) begin
					$error("partial_block expected %0d actual %0d", want.partial, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb_stereo_block_rms_meter_core failed");
			$finish;
		end
	end

	initial begin
		logic             got;
		logic             ign;
		rms_t             res;
		logic [CFG_W-1:0] bf;
		int               n_rand;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_AUDIO;
		cfg_we = 1'b0;
		cfg_index = REG_BLOCK_FRAMES;
		cfg_data = '0;
		quiet = 1'b0;
		errors = 0;
		n_frames = 0;
		n_flushes = 0;
		n_ignored = 0;
		n_results = 0;
		n_phases = 0;
		idle_cycles = 0;
		n_rand = 0;
		want_frames = srms_pkg::BLOCK_FRAMES_RST;
		want_fmt = srms_pkg::FORMAT_RST;
		want_stereo = srms_pkg::STEREO_RST;
		sumsq_l = '0;
		sumsq_r = '0;
		blk_count = 0;

		// op, reg, kind, left / reg value, right, check, typed result
		dir_steps = '{
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_NONE, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_7FFF, 32'hFFFF_8000, EXP_NONE, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_FLUSH, 32'hAAAA_AAAA, 32'h5555_5555, EXP_RES,
				'{16'd32767, 16'd32768, 1'b1}},
			'{OP_CFG, REG_BLOCK_FRAMES, KIND_AUDIO, 32'd1, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h7FFF_8000, 32'h8000_7FFF, EXP_RES,
				'{16'd32768, 16'd32767, 1'b0}},
			'{OP_CFG, REG_BLOCK_FRAMES, KIND_AUDIO, 32'd0, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_0000, 32'hFFFF_FFFF, EXP_RES,
				'{16'd0, 16'd1, 1'b0}},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_FLUSH, 32'h0, 32'h0, EXP_NONE, '0},
			'{OP_CFG, REG_SAMPLE_FORMAT, KIND_AUDIO, 32'(FMT_S32), 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h7FFF_FFFF, 32'h8000_0000, EXP_RES,
				'{16'd32767, 16'd32768, 1'b0}},
			'{OP_CFG, REG_BLOCK_FRAMES, KIND_AUDIO, 32'd3, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_FFFF, 32'hFFFF_0000, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h1234_5678, 32'hEDCB_A987, EXP_PRED, '0},
			'{OP_CFG, REG_SAMPLE_FORMAT, KIND_AUDIO, 32'(FMT_U8), 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_00FF, 32'hFFFF_FF00, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_0080, 32'h0000_007F, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_0000, 32'hFFFF_FFFF, EXP_PRED, '0},
			// shrink the block below the running count
			'{OP_CFG, REG_BLOCK_FRAMES, KIND_AUDIO, 32'd1, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_0080, 32'h0000_0080, EXP_PRED, '0},
			'{OP_CFG, REG_STEREO_MODE, KIND_AUDIO, 32'd0, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_0000, 32'h0000_00FF, EXP_RES,
				'{16'd32768, 16'd32768, 1'b0}},
			'{OP_CFG, REG_SAMPLE_FORMAT, KIND_AUDIO, 32'(FMT_BAD), 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_7FFF, 32'h0000_7FFF, EXP_NONE, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_FLUSH, 32'h0, 32'h0, EXP_NONE, '0},
			'{OP_CFG, REG_SAMPLE_FORMAT, KIND_AUDIO, 32'(FMT_S16), 32'd0, EXP_PRED, '0},
			'{OP_CFG, REG_STEREO_MODE, KIND_AUDIO, 32'd1, 32'd0, EXP_PRED, '0},
			'{OP_CFG, REG_BLOCK_FRAMES, KIND_AUDIO, 32'd4, 32'd0, EXP_PRED, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'h0000_1000, 32'h0000_0000, EXP_NONE, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_AUDIO, 32'hFFFF_F000, 32'h0000_0003, EXP_NONE, '0},
			'{OP_ITEM, REG_BLOCK_FRAMES, KIND_FLUSH, 32'h0, 32'h0, EXP_RES,
				'{16'd4096, 16'd2, 1'b1}}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_steps[i]) begin
			if (dir_steps[i].op == OP_CFG) begin
				drain(SETTLE);
				cfg_write(dir_steps[i].idx, dir_steps[i].left);
			end else begin
				send(dir_steps[i].kind, dir_steps[i].left, dir_steps[i].right, got, res);
				if (dir_steps[i].chk == EXP_RES)
					rms_due.push_back(dir_steps[i].res);
				else if (dir_steps[i].chk == EXP_PRED && got)
					rms_due.push_back(res);
			end
		end

		while (n_rand < RAND_ITEMS) begin
			drain(SETTLE);
			n_phases++;
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 9))
					0: bf = '0;
					1, 2, 3, 4, 5, 6: bf = CFG_W'($urandom_range(1, 8));
					7, 8: bf = CFG_W'($urandom_range(9, 64));
					default: bf = CFG_W'($urandom_range(65, 300));
				endcase
				cfg_write(REG_BLOCK_FRAMES, 32'(bf));
			end
			if ($urandom_range(0, 1) == 1)
				cfg_write(REG_SAMPLE_FORMAT,
					($urandom_range(0, 9) == 0) ? 32'(FMT_BAD) : 32'($urandom_range(0, 2)));
			if ($urandom_range(0, 1) == 1)
				cfg_write(REG_STEREO_MODE, 32'($urandom_range(0, 1)));
			repeat ($urandom_range(5, 40)) begin
				if ($urandom_range(0, 49) == 0)
					drain(0);
				if ($urandom_range(0, 11) == 0) begin
					ign = 1'b0;
					send(KIND_FLUSH, $urandom, $urandom, got, res);
				end else begin
					ign = (want_fmt == FMT_BAD);
					send(KIND_AUDIO, pick_sample(), pick_sample(), got, res);
				end
				if (got)
					rms_due.push_back(res);
				if (!ign)
					n_rand++;
			end
		end

		drain(SETTLE);
		$display("covered %0d audio frames, %0d flushes and %0d frames of an unknown format",
			n_frames, n_flushes, n_ignored);
		$display("over %0d register settings; %0d block results checked, %0d mismatches",
			n_phases, n_results, errors);
		if (errors == 0 && rms_due.size() == 0)
			$display("tb_stereo_block_rms_meter_core passed");
		else
			$display("tb_stereo_block_rms_meter_core failed");
		$finish;
	end

endmodule
